// ===== rtl/baqe_pkg.sv =====
`timescale 1ns / 1ps

package baqe_pkg;

    localparam int DEF_QUEUE_SLOTS = 16;

    localparam logic [3:0] MAX_ENTRIES_RESET = 4'd15;

    // Request codes carried in req_type.
    localparam logic [1:0] REQ_ADMIT  = 2'd0;
    localparam logic [1:0] REQ_EXPIRE = 2'd1;
    localparam logic [1:0] REQ_POP    = 2'd2;
    localparam logic [1:0] REQ_NONE   = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] action_payload;
        logic        entry_evictable;
        logic [31:0] time_stamp;
        logic [31:0] window_len;
    } req_beat_t;

    typedef struct packed {
        logic [3:0]  removed_count;
        logic        pop_valid;
        logic [15:0] pop_payload;
        logic        pop_evictable;
        logic [4:0]  occupancy;
    } rsp_beat_t;

    // One queue slot as it is held in the slot memory.
    typedef struct packed {
        logic [15:0] payload;
        logic        evictable;
        logic [31:0] time_stamp;
    } slot_entry_t;

endpackage

// ===== rtl/baqe_slot_ram.sv =====
`timescale 1ns / 1ps

module baqe_slot_ram
    import baqe_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_SLOTS,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  slot_entry_t   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output slot_entry_t   rdata
);

    slot_entry_t mem [DEPTH];
    slot_entry_t rdata_reg;

    // One write port and one read port; read data is registered, appearing in the cycle after the read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bounded_action_queue_evict.sv =====
`timescale 1ns / 1ps

// Channel    Direction  Handshake               Beat
// req        in         req_valid / req_ready   req_beat_t (admit, expire, pop)
// rsp        out        rsp_valid / rsp_ready   rsp_beat_t (one per request)
// cfg        in         cfg_we, no wait         cfg_wdata = max_entries
//
// One request is worked at a time. An admit without eviction goes straight to
// the finish step; an admit with eviction walks the slot memory twice over all
// entries including the new one (count evictable entries, then compact), and
// expire and pop walk it at most once. The slot memory has a single read port,
// and a walk reads one slot per cycle.
// Reset clears the entry count, not the slot contents; those need no clearing pass.
// A held result does not block acceptance of the next request; that request's
// finish step waits for it, and req_ready stays low meanwhile.

module bounded_action_queue_evict
    import baqe_pkg::*;
#(
    parameter int QUEUE_SLOTS = DEF_QUEUE_SLOTS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  req_beat_t  req,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output rsp_beat_t  rsp,
    input  logic       cfg_we,
    input  logic [3:0] cfg_wdata
);

    localparam int AW = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam int CW = $clog2(QUEUE_SLOTS + 1);
    localparam int BW = (CW > 4) ? CW : 4;
    localparam logic [BW-1:0] BOUND_CAP = BW'(QUEUE_SLOTS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COUNT,
        ST_COMPACT,
        ST_FINISH
    } state_t;

    state_t        state_reg, state_next;
    logic [1:0]    op_reg, op_next;
    logic [31:0]   ts_reg, ts_next;
    logic [31:0]   win_reg, win_next;
    logic [3:0]    max_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] scan_cnt_reg, scan_cnt_next;
    logic [CW-1:0] iss_reg, iss_next;
    logic          rd_vld_reg, rd_vld_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic [CW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0] drop_reg, drop_next;
    logic [CW-1:0] ev_tot_reg, ev_tot_next;
    logic [CW-1:0] ev_seen_reg, ev_seen_next;
    logic [CW-1:0] ne_seen_reg, ne_seen_next;
    logic [CW-1:0] k_reg, k_next;
    logic          k_le_e_reg, k_le_e_next;
    logic          pop_vld_reg, pop_vld_next;
    logic [15:0]   pop_pay_reg, pop_pay_next;
    logic          pop_ev_reg, pop_ev_next;
    rsp_beat_t     rsp_reg, rsp_next;
    logic          rsp_valid_reg, rsp_valid_next;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    slot_entry_t   mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    slot_entry_t   mem_rdata;

    logic [BW-1:0] bound_w;
    logic [CW-1:0] bound;
    logic [CW-1:0] cnt_plus;
    logic          is_last;
    logic [31:0]   age;
    logic [CW:0]   ne_sum;
    logic          drop_sel;

    baqe_slot_ram #(
        .DEPTH (QUEUE_SLOTS),
        .AW    (AW)
    ) u_slot_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Bound in use: a zero setting acts as one, and the bound never exceeds
    // the slot count less one, so an admit always finds a free slot.
    always_comb
    begin
        bound_w = (max_reg == 4'd0) ? BW'(1) : BW'(max_reg);
        if (bound_w > BOUND_CAP)
        begin
            bound_w = BOUND_CAP;
        end
    end

    assign bound    = CW'(bound_w);
    assign cnt_plus = cnt_reg + CW'(1);
    assign is_last  = (rd_idx_reg == scan_cnt_reg - CW'(1));
    assign age      = ts_reg - mem_rdata.time_stamp;
    assign ne_sum   = {1'b0, ne_seen_reg} + {1'b0, ev_tot_reg};

    // Drop decision for the slot whose read data is present this cycle. The
    // newest entry always survives admit and expire. For an admit that must
    // remove k entries: with at least k evictable entries ahead of the newest,
    // the first k of them go; otherwise every evictable one goes, and the
    // remaining removals take the oldest non-evictable entries in order.
    always_comb
    begin
        case (op_reg)
            REQ_ADMIT:
            begin
                if (is_last)
                begin
                    drop_sel = 1'b0;
                end
                else if (k_le_e_reg)
                begin
                    drop_sel = mem_rdata.evictable && (ev_seen_reg < k_reg);
                end
                else
                begin
                    drop_sel = mem_rdata.evictable || (ne_sum < {1'b0, k_reg});
                end
            end
            REQ_EXPIRE:
            begin
                drop_sel = !is_last && mem_rdata.evictable && (age > win_reg);
            end
            REQ_POP:
            begin
                drop_sel = (rd_idx_reg == '0);
            end
            default:
            begin
                drop_sel = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        ts_next        = ts_reg;
        win_next       = win_reg;
        cnt_next       = cnt_reg;
        scan_cnt_next  = scan_cnt_reg;
        iss_next       = iss_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = rd_idx_reg;
        wr_ptr_next    = wr_ptr_reg;
        drop_next      = drop_reg;
        ev_tot_next    = ev_tot_reg;
        ev_seen_next   = ev_seen_reg;
        ne_seen_next   = ne_seen_reg;
        k_next         = k_reg;
        k_le_e_next    = k_le_e_reg;
        pop_vld_next   = pop_vld_reg;
        pop_pay_next   = pop_pay_reg;
        pop_ev_next    = pop_ev_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        mem_we    = 1'b0;
        mem_waddr = wr_ptr_reg[AW-1:0];
        mem_wdata = mem_rdata;
        mem_re    = 1'b0;
        mem_raddr = iss_reg[AW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next       = req.req_type;
                    ts_next       = req.time_stamp;
                    win_next      = req.window_len;
                    iss_next      = '0;
                    wr_ptr_next   = '0;
                    drop_next     = '0;
                    ev_tot_next   = '0;
                    ev_seen_next  = '0;
                    ne_seen_next  = '0;
                    pop_vld_next  = 1'b0;
                    pop_pay_next  = '0;
                    pop_ev_next   = 1'b0;
                    scan_cnt_next = cnt_reg;
                    state_next    = ST_FINISH;
                    unique case (req.req_type)
                        REQ_ADMIT:
                        begin
                            // Append at the tail; the count stays below the
                            // slot count, so the address always fits.
                            mem_we              = 1'b1;
                            mem_waddr           = cnt_reg[AW-1:0];
                            mem_wdata.payload   = req.action_payload;
                            mem_wdata.evictable = req.entry_evictable;
                            mem_wdata.time_stamp = req.time_stamp;
                            cnt_next            = cnt_plus;
                            scan_cnt_next       = cnt_plus;
                            k_next              = cnt_plus - bound;
                            if (cnt_plus > bound)
                            begin
                                state_next = ST_COUNT;
                            end
                        end
                        REQ_EXPIRE:
                        begin
                            if (cnt_reg > CW'(1))
                            begin
                                state_next = ST_COMPACT;
                            end
                        end
                        REQ_POP:
                        begin
                            if (cnt_reg != '0)
                            begin
                                state_next = ST_COMPACT;
                            end
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_COUNT, ST_COMPACT:
            begin
                if (iss_reg < scan_cnt_reg)
                begin
                    mem_re      = 1'b1;
                    rd_vld_next = 1'b1;
                    rd_idx_next = iss_reg;
                    iss_next    = iss_reg + CW'(1);
                end

                if (rd_vld_reg)
                begin
                    if (state_reg == ST_COUNT)
                    begin
                        if (mem_rdata.evictable && !is_last)
                        begin
                            ev_tot_next = ev_tot_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        // Kept entries are written back at the write pointer,
                        // which never passes the slot just read, so no slot
                        // still to be read is overwritten.
                        if (drop_sel)
                        begin
                            drop_next = drop_reg + CW'(1);
                        end
                        else
                        begin
                            mem_we      = 1'b1;
                            wr_ptr_next = wr_ptr_reg + CW'(1);
                        end
                        if (mem_rdata.evictable)
                        begin
                            ev_seen_next = ev_seen_reg + CW'(1);
                        end
                        else
                        begin
                            ne_seen_next = ne_seen_reg + CW'(1);
                        end
                        if (op_reg == REQ_POP && rd_idx_reg == '0)
                        begin
                            pop_vld_next = 1'b1;
                            pop_pay_next = mem_rdata.payload;
                            pop_ev_next  = mem_rdata.evictable;
                        end
                    end
                end

                if (iss_reg == scan_cnt_reg && !rd_vld_reg)
                begin
                    if (state_reg == ST_COUNT)
                    begin
                        iss_next    = '0;
                        k_le_e_next = (k_reg <= ev_tot_reg);
                        state_next  = ST_COMPACT;
                    end
                    else
                    begin
                        cnt_next   = wr_ptr_reg;
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    // The entry a pop returns is not reported as removed.
                    rsp_next.removed_count = (op_reg == REQ_POP) ? 4'd0 : 4'(drop_reg);
                    rsp_next.pop_valid     = pop_vld_reg;
                    rsp_next.pop_payload   = pop_pay_reg;
                    rsp_next.pop_evictable = pop_ev_reg;
                    rsp_next.occupancy     = 5'(cnt_reg);
                    rsp_valid_next         = 1'b1;
                    state_next             = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= REQ_NONE;
            ts_reg        <= '0;
            win_reg       <= '0;
            max_reg       <= MAX_ENTRIES_RESET;
            cnt_reg       <= '0;
            scan_cnt_reg  <= '0;
            iss_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            rd_idx_reg    <= '0;
            wr_ptr_reg    <= '0;
            drop_reg      <= '0;
            ev_tot_reg    <= '0;
            ev_seen_reg   <= '0;
            ne_seen_reg   <= '0;
            k_reg         <= '0;
            k_le_e_reg    <= 1'b0;
            pop_vld_reg   <= 1'b0;
            pop_pay_reg   <= '0;
            pop_ev_reg    <= 1'b0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            ts_reg        <= ts_next;
            win_reg       <= win_next;
            if (cfg_we)
            begin
                max_reg <= cfg_wdata;
            end
            cnt_reg       <= cnt_next;
            scan_cnt_reg  <= scan_cnt_next;
            iss_reg       <= iss_next;
            rd_vld_reg    <= rd_vld_next;
            rd_idx_reg    <= rd_idx_next;
            wr_ptr_reg    <= wr_ptr_next;
            drop_reg      <= drop_next;
            ev_tot_reg    <= ev_tot_next;
            ev_seen_reg   <= ev_seen_next;
            ne_seen_reg   <= ne_seen_next;
            k_reg         <= k_next;
            k_le_e_reg    <= k_le_e_next;
            pop_vld_reg   <= pop_vld_next;
            pop_pay_reg   <= pop_pay_next;
            pop_ev_reg    <= pop_ev_next;
            rsp_reg       <= rsp_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The queue never holds a full set of slots between requests.
    a_cnt_below_slots: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (cnt_reg <= CW'(QUEUE_SLOTS - 1)))
        else $error("entry count reached the slot count");

    // A compaction write-back never lands beyond the slot being processed.
    a_wb_behind_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMPACT && mem_we) |-> (wr_ptr_reg <= rd_idx_reg))
        else $error("compaction write passed the read position");

    // After an admit the entry count respects the bound in use.
    a_admit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && op_reg == REQ_ADMIT) |-> (cnt_reg <= bound))
        else $error("admit left more entries than the bound");

    // A pop removes exactly the entry it returns, and nothing otherwise.
    a_pop_single: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && op_reg == REQ_POP) |-> (drop_reg == CW'(pop_vld_reg)))
        else $error("pop removed a wrong number of entries");

endmodule
